[sv/chd_pkg.sv]
// Shared types, codes and defaults of the canonical Huffman tree decoder.
package chd_pkg;

  localparam int NUM_SYMBOLS_DEF  = 288;
  localparam int MAX_CODE_LEN_DEF = 15;

  // Reset values of the configuration registers
  localparam logic [8:0] NUM_CODES_RST  = 9'd288;
  localparam logic [3:0] MAX_LENGTH_RST = 4'd15;

  // Input commands
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_BUILD  = 2'd1;
  localparam logic [1:0] CMD_DECODE = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BUILD_ERR = 2'd1;
  localparam logic [1:0] ST_BAD_POS   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_NUM_CODES  = 2'd0;
  localparam logic [1:0] REG_MAX_LENGTH = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_CNT,
    S_NXT,
    S_ASN,
    S_TSYM,
    S_TLD,
    S_TRD,
    S_TWR,
    S_DRD
  } state_t;

  // Datapath operation for the current cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INIT,
    OP_CLR,
    OP_CNT,
    OP_NXT,
    OP_ASN,
    OP_TSYM,
    OP_TLD,
    OP_TRD,
    OP_TWR,
    OP_BOK,
    OP_BERR,
    OP_DEC,
    OP_DRES
  } op_t;

  typedef struct packed {
    op_t  op;
    logic res_ld;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic cnt_done;
    logic nxt_done;
    logic err;
    logic tlen_zero;
    logic tlast;
    logic tsym_end;
    logic ovf;
    logic dec_bad;
  } stat_t;

endpackage

[sv/chd_ctrl.sv]
// Sequencer of the decoder: handshakes, build phases and result register control.
module chd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [1:0]     in_cmd,
  output logic           out_tvalid,
  input  logic           out_tready,
  output chd_pkg::cmd_t  cmd,
  input  chd_pkg::stat_t stat
);

  chd_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;

  assign in_tready  = (state_r == chd_pkg::S_IDLE) && (!out_valid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  // Hold state and result flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chd_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt  = state_r;
    cmd.op     = chd_pkg::OP_NONE;
    cmd.res_ld = 1'b0;
    case (state_r)
      chd_pkg::S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            chd_pkg::CMD_LOAD: begin
              cmd.op     = chd_pkg::OP_LOAD;
              cmd.res_ld = 1'b1;
            end
            chd_pkg::CMD_BUILD: begin
              cmd.op    = chd_pkg::OP_INIT;
              state_nxt = chd_pkg::S_CLR;
            end
            chd_pkg::CMD_DECODE: begin
              cmd.op = chd_pkg::OP_DEC;
              if (stat.dec_bad) begin
                cmd.res_ld = 1'b1;
              end else begin
                state_nxt = chd_pkg::S_DRD;
              end
            end
            default: begin
              cmd.res_ld = 1'b1;
            end
          endcase
        end
      end
      chd_pkg::S_CLR: begin
        cmd.op = chd_pkg::OP_CLR;
        if (stat.clr_last) state_nxt = chd_pkg::S_CNT;
      end
      chd_pkg::S_CNT: begin
        cmd.op = chd_pkg::OP_CNT;
        if (stat.cnt_done) state_nxt = chd_pkg::S_NXT;
      end
      chd_pkg::S_NXT: begin
        if (stat.err) begin
          cmd.op     = chd_pkg::OP_BERR;
          cmd.res_ld = 1'b1;
          state_nxt  = chd_pkg::S_IDLE;
        end else begin
          cmd.op = chd_pkg::OP_NXT;
          if (stat.nxt_done) state_nxt = chd_pkg::S_ASN;
        end
      end
      chd_pkg::S_ASN: begin
        cmd.op = chd_pkg::OP_ASN;
        if (stat.cnt_done) state_nxt = chd_pkg::S_TSYM;
      end
      chd_pkg::S_TSYM: begin
        if (stat.tsym_end) begin
          cmd.op     = chd_pkg::OP_BOK;
          cmd.res_ld = 1'b1;
          state_nxt  = chd_pkg::S_IDLE;
        end else begin
          cmd.op    = chd_pkg::OP_TSYM;
          state_nxt = chd_pkg::S_TLD;
        end
      end
      chd_pkg::S_TLD: begin
        cmd.op    = chd_pkg::OP_TLD;
        state_nxt = stat.tlen_zero ? chd_pkg::S_TSYM : chd_pkg::S_TRD;
      end
      chd_pkg::S_TRD: begin
        if (stat.ovf) begin
          cmd.op     = chd_pkg::OP_BERR;
          cmd.res_ld = 1'b1;
          state_nxt  = chd_pkg::S_IDLE;
        end else begin
          cmd.op    = chd_pkg::OP_TRD;
          state_nxt = chd_pkg::S_TWR;
        end
      end
      chd_pkg::S_TWR: begin
        cmd.op    = chd_pkg::OP_TWR;
        state_nxt = stat.tlast ? chd_pkg::S_TSYM : chd_pkg::S_TRD;
      end
      chd_pkg::S_DRD: begin
        cmd.op     = chd_pkg::OP_DRES;
        cmd.res_ld = 1'b1;
        state_nxt  = chd_pkg::S_IDLE;
      end
      default: begin
        state_nxt = chd_pkg::S_IDLE;
      end
    endcase
  end

  // Load or drain the result flag
  always_comb begin
    if (cmd.res_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

`ifndef SYNTHESIS
  // A new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_ld |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

  // A tree write step returns to the next bit or the next symbol
  a_twr_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == chd_pkg::S_TWR) |=> (state_r == chd_pkg::S_TRD || state_r == chd_pkg::S_TSYM))
    else $error("bad step after tree write");

  // An accepted build starts with the clearing sweep
  a_build_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == chd_pkg::CMD_BUILD) |=> (state_r == chd_pkg::S_CLR))
    else $error("build did not start clearing");
`endif

endmodule

[sv/chd_dp.sv]
// Datapath of the decoder: stores, counters, tree walk and result payload.
module chd_dp #(
  parameter int NUM_SYMBOLS  = chd_pkg::NUM_SYMBOLS_DEF,
  parameter int MAX_CODE_LEN = chd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_valid,
  input  logic [1:0]     cfg_addr,
  input  logic [8:0]     cfg_data,
  input  logic [8:0]     in_idx,
  input  logic [3:0]     in_len,
  input  logic           in_bit,
  input  chd_pkg::cmd_t  cmd,
  output chd_pkg::stat_t stat,
  output logic [1:0]     out_status,
  output logic           out_decoded,
  output logic [8:0]     out_symbol
);

  localparam int LW = $clog2(NUM_SYMBOLS);
  localparam int SW = $clog2(2 * NUM_SYMBOLS);
  localparam int EW = SW;
  localparam int PW = EW + 1;
  localparam int NW = $clog2(NUM_SYMBOLS + 1);
  localparam logic [3:0] LIM_MAX = 4'(MAX_CODE_LEN);

  // Configuration registers
  logic [8:0] cfg_nc_r;
  logic [3:0] cfg_ml_r;

  // Build working registers
  logic [NW-1:0] nc_r;
  logic [3:0]    lim_r;
  logic [SW-1:0] cnt_r;
  logic          rd_vld_r;
  logic [LW-1:0] rd_adr_r;
  logic          err_r;
  logic [3:0]    i_r;
  logic [3:0]    len_r;
  logic [14:0]   code_r;
  logic [PW-1:0] pos_r;
  logic [LW-1:0] nodes_r;
  logic [SW-1:0] slot_r;
  logic [NW-1:0] counts_r [16];
  logic [15:0]   nexts_r  [16];

  // Decode registers
  logic [NW-1:0] tsize_r;
  logic [NW-1:0] dpos_r;

  // Memories and their registered read data
  logic [3:0]  len_mem  [NUM_SYMBOLS];
  logic [14:0] code_mem [NUM_SYMBOLS];
  logic [EW:0] tree_mem [2*NUM_SYMBOLS];
  logic [3:0]  len_rd_r;
  logic [14:0] code_rd_r;
  logic [EW:0] tree_rd_r;

  logic [1:0]    res_status;
  logic          res_dec;
  logic [8:0]    res_sym;
  logic [1:0]    out_status_r;
  logic          out_dec_r;
  logic [8:0]    out_sym_r;

  logic [NW-1:0] nc_sat;
  logic [3:0]    lim_sat;
  logic          cur_bit;
  logic [SW-1:0] bslot;
  logic [SW-1:0] dslot;
  logic          t_full;
  logic [EW-1:0] t_val;
  logic          t_leaf;
  logic [EW-1:0] wval;
  logic [16:0]   nsum;
  logic [3:0]    im1;

  // Saturate registers for a build
  always_comb begin
    if (cfg_nc_r < 9'd2) begin
      nc_sat = NW'(2);
    end else if (int'(cfg_nc_r) > NUM_SYMBOLS) begin
      nc_sat = NW'(NUM_SYMBOLS);
    end else begin
      nc_sat = NW'(cfg_nc_r);
    end
    lim_sat = (cfg_ml_r > LIM_MAX) ? LIM_MAX : cfg_ml_r;
  end

  assign cur_bit = code_r[4'(len_r - i_r - 4'd1)];
  assign bslot   = {pos_r[SW-2:0], cur_bit};
  assign dslot   = {dpos_r[SW-2:0], in_bit};
  assign t_full  = tree_rd_r[EW];
  assign t_val   = tree_rd_r[EW-1:0];
  assign t_leaf  = int'(t_val) < int'(tsize_r);
  assign wval    = stat.tlast ? EW'(cnt_r) : (EW'(nodes_r) + EW'(1) + EW'(nc_r));
  assign im1     = i_r - 4'd1;
  assign nsum    = 17'(nexts_r[im1]) + 17'(counts_r[im1]);

  // Status toward the sequencer
  always_comb begin
    stat.clr_last  = int'(cnt_r) == 2 * int'(nc_r) - 1;
    stat.cnt_done  = rd_vld_r && (int'(cnt_r) == int'(nc_r));
    stat.nxt_done  = i_r == 4'd15;
    stat.err       = err_r;
    stat.tlen_zero = len_rd_r == 4'd0;
    stat.tlast     = (i_r + 4'd1) == len_r;
    stat.tsym_end  = int'(cnt_r) == int'(nc_r);
    stat.ovf       = int'(pos_r) > int'(nc_r) - 2;
    stat.dec_bad   = (tsize_r == '0) || (dpos_r >= tsize_r);
  end

  // Result fields for the current operation
  always_comb begin
    res_status = chd_pkg::ST_OK;
    res_dec    = 1'b0;
    res_sym    = 9'd0;
    case (cmd.op)
      chd_pkg::OP_DEC: begin
        if (stat.dec_bad) res_status = chd_pkg::ST_BAD_POS;
      end
      chd_pkg::OP_BERR: begin
        res_status = chd_pkg::ST_BUILD_ERR;
      end
      chd_pkg::OP_DRES: begin
        if (t_full && t_leaf) begin
          res_dec = 1'b1;
          res_sym = 9'(t_val);
        end
      end
      default: begin
        res_status = chd_pkg::ST_OK;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_nc_r <= chd_pkg::NUM_CODES_RST;
      cfg_ml_r <= chd_pkg::MAX_LENGTH_RST;
    end else if (cfg_valid) begin
      if (cfg_addr == chd_pkg::REG_NUM_CODES) cfg_nc_r <= cfg_data;
      if (cfg_addr == chd_pkg::REG_MAX_LENGTH) cfg_ml_r <= cfg_data[3:0];
    end
  end

  // Decode position and tree size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsize_r <= '0;
      dpos_r  <= '0;
    end else begin
      case (cmd.op)
        chd_pkg::OP_INIT: begin
          tsize_r <= '0;
          dpos_r  <= '0;
        end
        chd_pkg::OP_BOK: begin
          tsize_r <= nc_r;
        end
        chd_pkg::OP_DRES: begin
          if (!t_full) begin
            dpos_r <= tsize_r;
          end else if (t_leaf) begin
            dpos_r <= '0;
          end else begin
            dpos_r <= NW'(t_val - EW'(tsize_r));
          end
        end
        default: begin
          dpos_r <= dpos_r;
        end
      endcase
    end
  end

  // Build sequencing registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      chd_pkg::OP_INIT: begin
        nc_r     <= nc_sat;
        lim_r    <= lim_sat;
        cnt_r    <= '0;
        rd_vld_r <= 1'b0;
        err_r    <= 1'b0;
        pos_r    <= '0;
        nodes_r  <= '0;
        for (int k = 0; k < 16; k++) begin
          counts_r[k] <= '0;
          nexts_r[k]  <= '0;
        end
      end
      chd_pkg::OP_CLR: begin
        cnt_r    <= stat.clr_last ? '0 : cnt_r + SW'(1);
        rd_vld_r <= 1'b0;
      end
      chd_pkg::OP_CNT, chd_pkg::OP_ASN: begin
        // issue the next length read, consume the previous one
        rd_vld_r <= int'(cnt_r) < int'(nc_r);
        rd_adr_r <= cnt_r[LW-1:0];
        if (int'(cnt_r) < int'(nc_r)) cnt_r <= cnt_r + SW'(1);
        if (rd_vld_r) begin
          if (cmd.op == chd_pkg::OP_CNT) begin
            if (len_rd_r > lim_r) begin
              err_r <= 1'b1;
            end else if (len_rd_r != 4'd0) begin
              counts_r[len_rd_r] <= counts_r[len_rd_r] + NW'(1);
            end
          end else if (len_rd_r != 4'd0) begin
            nexts_r[len_rd_r] <= nexts_r[len_rd_r] + 16'd1;
          end
        end
        if (stat.cnt_done) begin
          i_r      <= 4'd1;
          cnt_r    <= '0;
          rd_vld_r <= 1'b0;
        end
      end
      chd_pkg::OP_NXT: begin
        nexts_r[i_r] <= {nsum[14:0], 1'b0};
        i_r          <= i_r + 4'd1;
        cnt_r        <= '0;
        rd_vld_r     <= 1'b0;
      end
      chd_pkg::OP_TLD: begin
        len_r  <= len_rd_r;
        code_r <= code_rd_r;
        i_r    <= 4'd0;
        if (len_rd_r == 4'd0) cnt_r <= cnt_r + SW'(1);
      end
      chd_pkg::OP_TRD: begin
        slot_r <= bslot;
      end
      chd_pkg::OP_TWR: begin
        i_r <= i_r + 4'd1;
        if (stat.tlast) cnt_r <= cnt_r + SW'(1);
        if (!t_full) begin
          if (stat.tlast) begin
            pos_r <= '0;
          end else begin
            nodes_r <= nodes_r + LW'(1);
            pos_r   <= PW'(nodes_r) + PW'(1);
          end
        end else begin
          pos_r <= PW'(t_val) - PW'(nc_r);
        end
      end
      default: begin
        rd_vld_r <= rd_vld_r;
      end
    endcase
  end

  // Length store
  always_ff @(posedge clk) begin
    if (cmd.op == chd_pkg::OP_LOAD && int'(in_idx) < NUM_SYMBOLS) begin
      len_mem[LW'(in_idx)] <= in_len;
    end
    if (int'(cnt_r) < NUM_SYMBOLS) len_rd_r <= len_mem[cnt_r[LW-1:0]];
  end

  // Assigned code store
  always_ff @(posedge clk) begin
    if (cmd.op == chd_pkg::OP_ASN && rd_vld_r && len_rd_r != 4'd0) begin
      code_mem[rd_adr_r] <= nexts_r[len_rd_r][14:0];
    end
    if (int'(cnt_r) < NUM_SYMBOLS) code_rd_r <= code_mem[cnt_r[LW-1:0]];
  end

  // Tree store: full flag on top of each entry
  always_ff @(posedge clk) begin
    if (cmd.op == chd_pkg::OP_CLR) begin
      tree_mem[cnt_r] <= '0;
    end else if (cmd.op == chd_pkg::OP_TWR && !t_full) begin
      tree_mem[slot_r] <= {1'b1, wval};
    end
    if (cmd.op == chd_pkg::OP_TRD) begin
      tree_rd_r <= tree_mem[bslot];
    end else if (cmd.op == chd_pkg::OP_DEC) begin
      tree_rd_r <= tree_mem[dslot];
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      out_status_r <= res_status;
      out_dec_r    <= res_dec;
      out_sym_r    <= res_sym;
    end
  end

  assign out_status  = out_status_r;
  assign out_decoded = out_dec_r;
  assign out_symbol  = out_sym_r;

endmodule

[sv/canonical_huffman_tree_decoder.sv]
// Top level of the canonical Huffman tree decoder.
//
// Each input transfer is one command: load a symbol's code length, build the
// tree, or walk one coded bit; each gives exactly one result transfer. Loads
// and unused commands load their result as they are accepted; a decode reads
// the tree entry in a read state first, unless the kept position is already
// invalid. A build runs through the single-ported tree store and length
// store: clearing the tree, counting lengths, forming first codes, assigning
// codes, and filling the tree symbol by symbol and code bit by code bit. A
// finished result sits in an output register, so the next command is
// accepted in the cycle that result is taken.
module canonical_huffman_tree_decoder #(
  parameter int NUM_SYMBOLS  = chd_pkg::NUM_SYMBOLS_DEF,
  parameter int MAX_CODE_LEN = chd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [8:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // symbol_index[8:0], code_length[12:9], code_bit[13]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // symbol[8:0]
  output logic [2:0]  out_tuser   // status[1:0], decoded[2]
);

  chd_pkg::cmd_t  cmd;
  chd_pkg::stat_t stat;
  logic [1:0]     status;
  logic           decoded;
  logic [8:0]     symbol;

  assign cfg_ready = 1'b1;

  chd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  chd_dp #(
    .NUM_SYMBOLS  (NUM_SYMBOLS),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .in_idx      (in_tdata[8:0]),
    .in_len      (in_tdata[12:9]),
    .in_bit      (in_tdata[13]),
    .cmd         (cmd),
    .stat        (stat),
    .out_status  (status),
    .out_decoded (decoded),
    .out_symbol  (symbol)
  );

  assign out_tdata = {7'd0, symbol};
  assign out_tuser = {decoded, status};

endmodule

[tb/testbench.sv]
// Self-checking testbench of the canonical Huffman tree decoder.
`timescale 1ns / 100ps

module testbench;

  localparam int NSYM = 288;
  localparam int WATCH_LIMIT = 60000;
  // Command code with no function
  localparam logic [1:0] CMD_NONE = 2'd3;

  // Expected result of one command
  typedef struct packed {
    logic [1:0] status;
    logic       decoded;
    logic [8:0] symbol;
  } huff_res_t;

  // Predictor of the decoder and the queue of results it owes
  class huff_scoreboard;
    logic [3:0]  lengths[NSYM];
    logic [15:0] codes[NSYM];
    logic [9:0]  tree_val[2*NSYM];
    bit          tree_used[2*NSYM];
    int          position;
    int          tree_size;
    int          num_codes;
    int          max_len;
    huff_res_t   pending[$];
    int          errors;

    function void init();
      for (int i = 0; i < NSYM; i++) begin
        lengths[i] = 0;
        codes[i] = 0;
      end
      for (int i = 0; i < 2*NSYM; i++) tree_used[i] = 0;
      position = 0;
      tree_size = 0;
      num_codes = chd_pkg::NUM_CODES_RST;
      max_len = chd_pkg::MAX_LENGTH_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] addr, logic [8:0] data);
      if (addr == chd_pkg::REG_NUM_CODES) num_codes = data;
      else if (addr == chd_pkg::REG_MAX_LENGTH) max_len = data[3:0];
    endfunction

    function logic [1:0] build();
      int nc, lim, pos, nodes, len, slot;
      int cnt[16];
      int nxt[16];
      bit bitv;
      nc = num_codes;
      lim = max_len;
      pos = 0;
      nodes = 0;
      if (nc < 2) nc = 2;
      if (nc > NSYM) nc = NSYM;
      position = 0;
      tree_size = 0;
      for (int i = 0; i < 2*NSYM; i++) tree_used[i] = 0;
      for (int b = 0; b < 16; b++) begin
        cnt[b] = 0;
        nxt[b] = 0;
      end
      for (int n = 0; n < nc; n++) begin
        if (lengths[n] > lim) return chd_pkg::ST_BUILD_ERR;
        cnt[lengths[n]]++;
      end
      cnt[0] = 0;
      for (int b = 1; b < 16; b++) nxt[b] = ((nxt[b-1] + cnt[b-1]) << 1) & 16'hFFFF;
      for (int n = 0; n < nc; n++) begin
        len = lengths[n];
        if (len != 0) begin
          codes[n] = nxt[len] & 16'h7FFF;
          nxt[len] = (nxt[len] + 1) & 16'hFFFF;
        end
      end
      for (int n = 0; n < nc; n++) begin
        len = lengths[n];
        for (int i = 0; i < len; i++) begin
          bitv = codes[n][len-i-1];
          // a leaf reached mid-code leaves a wrapped, out-of-range position
          if (pos < 0 || pos > nc - 2) begin
            for (int k = 0; k < 2*NSYM; k++) tree_used[k] = 0;
            return chd_pkg::ST_BUILD_ERR;
          end
          slot = 2*pos + bitv;
          if (!tree_used[slot]) begin
            tree_used[slot] = 1;
            if (i + 1 == len) begin
              tree_val[slot] = n;
              pos = 0;
            end else begin
              nodes++;
              tree_val[slot] = nodes + nc;
              pos = nodes;
            end
          end else begin
            pos = tree_val[slot] - nc;
          end
        end
      end
      tree_size = nc;
      return chd_pkg::ST_OK;
    endfunction

    // Note one accepted command
    function void note_input(logic [1:0] cmd, logic [8:0] idx, logic [3:0] len, logic b);
      huff_res_t r;
      int slot, e;
      r = '0;
      if (cmd == chd_pkg::CMD_LOAD) begin
        if (idx < NSYM) lengths[idx] = len;
      end else if (cmd == chd_pkg::CMD_BUILD) begin
        r.status = build();
      end else if (cmd == chd_pkg::CMD_DECODE) begin
        if (tree_size == 0 || position >= tree_size) begin
          r.status = chd_pkg::ST_BAD_POS;
        end else begin
          slot = 2*position + b;
          if (!tree_used[slot]) begin
            position = tree_size;
          end else begin
            e = tree_val[slot];
            if (e < tree_size) begin
              r.decoded = 1;
              r.symbol = e;
              position = 0;
            end else begin
              position = e - tree_size;
            end
          end
        end
      end
      pending.push_back(r);
    endfunction

    // Compare one result with the oldest expectation
    function void check_result(logic [1:0] status, logic decoded, logic [8:0] symbol);
      huff_res_t r;
      if (pending.size() == 0) begin
        $error("unexpected result status=%0d decoded=%0d symbol=%0d", status, decoded, symbol);
        errors++;
        return;
      end
      r = pending.pop_front();
      if (status !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, status);
        errors++;
      end
      if (decoded !== r.decoded) begin
        $error("decoded: expected %0d, actual %0d", r.decoded, decoded);
        errors++;
      end
      if (symbol !== r.symbol) begin
        $error("symbol: expected %0d, actual %0d", r.symbol, symbol);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_addr = '0;
  logic [8:0]  cfg_data = '0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;

  huff_scoreboard sb;
  int  idle_pct = 28;
  int  stall_pct = 28;
  int  quiet_cycles = 0;
  int  cur_nc = 288;
  int  cur_ml = 15;

  canonical_huffman_tree_decoder dut (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_addr, .cfg_data,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  always #5 clk = ~clk;

  // Randomly stall the result side and check each result transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser[1:0], out_tuser[2], out_tdata[8:0]);
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCH_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Send one command, with a random gap before it; valid stays up until a gap or a drain
  task automatic send(logic [1:0] cmd, logic [8:0] idx, logic [3:0] len, logic b);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= cmd;
    in_tdata <= {2'b00, b, len, idx};
    do @(posedge clk); while (!in_tready);
    sb.note_input(cmd, idx, len, b);
  endtask

  // Drop valid, wait for all results, then let a build settle
  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] addr, logic [8:0] data);
    cfg_valid <= 1;
    cfg_addr <= addr;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(addr, data);
  endtask

  task automatic set_config(int nc, int ml);
    drain();
    write_reg(chd_pkg::REG_NUM_CODES, nc[8:0]);
    write_reg(chd_pkg::REG_MAX_LENGTH, ml[3:0]);
    cfg_valid <= 0;
    cur_nc = nc;
    cur_ml = ml;
  endtask

  // Load a random, mostly complete code over the active alphabet and build it
  task automatic load_random_code(int nc, int ml, bit broken);
    int kraft, len, maxb;
    kraft = 0;
    maxb = (ml > 15) ? 15 : ml;
    for (int s = 0; s < nc && s < NSYM; s++) begin
      len = 0;
      if ($urandom_range(3) != 0) begin
        len = $urandom_range(maxb, 1);
        if (kraft + (1 << (15 - len)) > 32768) len = 0;
      end
      if (broken && $urandom_range(9) == 0) len = $urandom_range(15);
      kraft += (len != 0) ? (1 << (15 - len)) : 0;
      send(chd_pkg::CMD_LOAD, s, len, $urandom_range(1));
    end
    send(chd_pkg::CMD_BUILD, $urandom_range(511), $urandom_range(15), $urandom_range(1));
  endtask

  int items;

  initial begin
    sb = new();
    sb.init();
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: decode before any tree, unused command, out-of-range load
    send(chd_pkg::CMD_DECODE, 0, 0, 0);
    send(CMD_NONE, 9'h1FF, 4'hF, 1);
    send(chd_pkg::CMD_LOAD, 9'h1FF, 4'hF, 1);
    send(chd_pkg::CMD_LOAD, 9'd300, 4'd3, 0);
    set_config(2, 1);
    // two symbols of length one: decode both
    send(chd_pkg::CMD_LOAD, 0, 1, 0);
    send(chd_pkg::CMD_LOAD, 1, 1, 1);
    send(chd_pkg::CMD_BUILD, 0, 0, 0);
    send(chd_pkg::CMD_DECODE, 0, 0, 0);
    send(chd_pkg::CMD_DECODE, 0, 0, 1);
    // bad length above max_length
    send(chd_pkg::CMD_LOAD, 1, 2, 0);
    send(chd_pkg::CMD_BUILD, 0, 0, 0);
    send(chd_pkg::CMD_DECODE, 0, 0, 1);
    // overflow: three symbols of length one
    set_config(3, 15);
    send(chd_pkg::CMD_LOAD, 0, 1, 0);
    send(chd_pkg::CMD_LOAD, 1, 1, 0);
    send(chd_pkg::CMD_LOAD, 2, 1, 0);
    send(chd_pkg::CMD_BUILD, 0, 0, 0);
    // incomplete code: decode into an empty entry, then invalid position
    send(chd_pkg::CMD_LOAD, 1, 0, 0);
    send(chd_pkg::CMD_LOAD, 2, 0, 0);
    send(chd_pkg::CMD_BUILD, 0, 0, 0);
    send(chd_pkg::CMD_DECODE, 0, 0, 1);
    send(chd_pkg::CMD_DECODE, 0, 0, 0);
    send(chd_pkg::CMD_DECODE, 0, 0, 0);
    // out-of-range register values saturate
    set_config(0, 15);
    send(chd_pkg::CMD_BUILD, 0, 0, 0);
    set_config(511, 0);
    for (int s = 0; s < NSYM; s++) send(chd_pkg::CMD_LOAD, s, 4'd15, 0);
    send(chd_pkg::CMD_BUILD, 0, 0, 0);
    set_config(288, 15);
    for (int s = 0; s < NSYM; s++) send(chd_pkg::CMD_LOAD, s, 0, 0);

    // Random phases: mostly small alphabets, a few full-size ones
    items = 0;
    for (int ph = 0; items < 1200; ph++) begin
      int nc, ml;
      idle_pct = (ph % 5 == 2) ? 0 : 28;
      stall_pct = (ph % 5 == 2) ? 0 : 28;
      nc = (ph % 9 == 8) ? 288 : $urandom_range(20, 2);
      ml = (ph % 4 == 0) ? 15 : $urandom_range(15, 1);
      set_config(nc, ml);
      load_random_code(nc, ml, $urandom_range(4) == 0);
      items += nc + 1;
      for (int k = 0; k < 40; k++) begin
        int r;
        r = $urandom_range(99);
        if (r < 85)
          send(chd_pkg::CMD_DECODE, $urandom_range(511), $urandom_range(15),
               $urandom_range(1));
        else if (r < 92)
          send(chd_pkg::CMD_LOAD, $urandom_range(511), $urandom_range(15),
               $urandom_range(1));
        else if (r < 96)
          send(CMD_NONE, $urandom_range(511), $urandom_range(15), $urandom_range(1));
        else
          send(chd_pkg::CMD_BUILD, $urandom_range(511), $urandom_range(15),
               $urandom_range(1));
      end
      items += 40;
    end

    drain();
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
